// ===== src/armcrc_pkg.sv =====
// armcrc_pkg: shared types, constants and helper functions for the radix-64 armor decoder
// no dependencies; imported by every module of the block
package armcrc_pkg;

	localparam logic [23:0] CRC_INIT = 24'hB704CE;
	localparam logic [24:0] CRC_POLY = 25'h1864CFB;
	localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ = 8'h3D;

	typedef enum logic [1:0] {
		PH_BODY = 2'd0,
		PH_WAIT = 2'd1,
		PH_SUM = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		RK_DATA = 2'd0,
		RK_GOOD = 2'd1,
		RK_BAD = 2'd2,
		RK_MALFORMED = 2'd3
	} res_kind_t;

	typedef enum logic [1:0] {
		JOB_BYTES = 2'd0,
		JOB_CHECK = 2'd1,
		JOB_ABORT = 2'd2
	} job_kind_t;

	// one entry of the queue between front and back
	typedef struct packed {
		job_kind_t kind;
		logic [1:0] count;
		logic [23:0] bits;
	} job_t;

	typedef struct packed {
		logic ok;
		logic pad;
		logic [5:0] val;
	} sym_t;

	function automatic sym_t sym_decode(input logic [7:0] c);
		sym_t s;
		s = '{ok: 1'b1, pad: 1'b0, val: 6'd0};
		if (c >= 8'h41 && c <= 8'h5A) begin
			s.val = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s.val = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s.val = 6'(c - 8'h30 + 8'd52);
		end else if (c == CH_PLUS) begin
			s.val = 6'd62;
		end else if (c == CH_SLASH) begin
			s.val = 6'd63;
		end else if (c == CH_EQ) begin
			s.pad = 1'b1;
		end else begin
			s.ok = 1'b0;
		end
		return s;
	endfunction

	function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] b);
		logic [24:0] r;
		r = {1'b0, crc ^ {b, 16'h0000}};
		for (int k = 0; k < 8; k++) begin
			r = {r[23:0], 1'b0};
			if (r[24]) begin
				r = r ^ CRC_POLY;
			end
		end
		return r[23:0];
	endfunction

endpackage

// ===== src/armcrc_front.sv =====
// armcrc_front: character classifier and quantum assembler
// depends on armcrc_pkg; emits at most one job per character into the job queue
module armcrc_front (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic [7:0] char_code,
	output logic job_push,
	output armcrc_pkg::job_t job
);
	import armcrc_pkg::*;

	phase_t phase_q, phase_n;
	logic [23:0] qbits_q, qbits_n;
	logic [1:0] idx_q, idx_n;
	logic [1:0] pad_q, pad_n;

	sym_t sym;
	logic [1:0] pad_inc;
	logic [23:0] qshift;
	logic is_space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BODY;
			qbits_q <= '0;
			idx_q <= '0;
			pad_q <= '0;
		end else if (take) begin
			phase_q <= phase_n;
			qbits_q <= qbits_n;
			idx_q <= idx_n;
			pad_q <= pad_n;
		end
	end

	always_comb begin
		sym = sym_decode(char_code);
		is_space = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
			(char_code == CH_LF) || (char_code == CH_CR);
		// pads only count in the body, and never past three
		pad_inc = (sym.pad && phase_q != PH_SUM && pad_q != 2'd3) ? pad_q + 2'd1 : pad_q;
		qshift = {qbits_q[17:0], sym.pad ? 6'd0 : sym.val};

		phase_n = phase_q;
		qbits_n = qbits_q;
		idx_n = idx_q;
		pad_n = pad_q;
		job_push = 1'b0;
		job = '{kind: JOB_BYTES, count: 2'd0, bits: 24'd0};

		if (char_code == CH_NUL) begin
			job_push = take;
			job.kind = JOB_ABORT;
			phase_n = PH_BODY;
			qbits_n = '0;
			idx_n = '0;
			pad_n = '0;
		end else if (phase_q == PH_WAIT) begin
			if (char_code == CH_EQ) begin
				phase_n = PH_SUM;
				qbits_n = '0;
				idx_n = '0;
				pad_n = '0;
			end else if (!is_space) begin
				job_push = take;
				job.kind = JOB_ABORT;
				phase_n = PH_BODY;
				qbits_n = '0;
				idx_n = '0;
				pad_n = '0;
			end
		end else if (sym.ok) begin
			if (sym.pad && idx_q == 2'd0) begin
				if (phase_q == PH_SUM) begin
					// pad as first checksum symbol: checksum value zero
					job_push = take;
					job.kind = JOB_CHECK;
					phase_n = PH_BODY;
					qbits_n = '0;
					pad_n = '0;
				end else begin
					phase_n = PH_SUM;
					qbits_n = '0;
					pad_n = '0;
				end
			end else if (idx_q != 2'd3) begin
				qbits_n = qshift;
				idx_n = idx_q + 2'd1;
				pad_n = pad_inc;
			end else begin
				idx_n = '0;
				qbits_n = '0;
				pad_n = '0;
				if (phase_q == PH_SUM) begin
					job_push = take;
					job.kind = JOB_CHECK;
					job.bits = qshift;
					phase_n = PH_BODY;
				end else begin
					job_push = take && (pad_inc != 2'd3);
					job.kind = JOB_BYTES;
					job.count = 2'd3 - pad_inc;
					job.bits = qshift;
					if (pad_inc != 2'd0) begin
						phase_n = PH_WAIT;
					end
				end
			end
		end
	end

endmodule

// ===== src/armcrc_queue.sv =====
// armcrc_queue: small job queue between front and back
// depends on armcrc_pkg for the job type and depth
module armcrc_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input armcrc_pkg::job_t wr_job,
	output logic full,
	input logic rd_en,
	output logic rd_valid,
	output armcrc_pkg::job_t rd_job
);
	import armcrc_pkg::*;

	job_t slots_q [QDEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QAW:0] count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + (QAW+1)'(wr_en) - (QAW+1)'(rd_en);
		end
	end

	assign full = (count_q == (QAW+1)'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job = slots_q[rptr_q];

endmodule

// ===== src/armcrc_back.sv =====
// armcrc_back: executes jobs, one result per cycle while results are popped, with crc-24 and byte count
// depends on armcrc_pkg; drives the registered result ports
module armcrc_back (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input armcrc_pkg::job_t job,
	output logic job_done,
	output logic empty,
	input logic pop,
	output logic [1:0] result_kind,
	output logic [7:0] data_byte,
	output logic [15:0] decoded_total,
	output logic last_of_run
);
	import armcrc_pkg::*;

	logic [23:0] crc_q;
	logic [15:0] total_q;
	logic [1:0] k_q;
	logic out_valid_q;
	res_kind_t kind_q;
	logic [7:0] byte_q;
	logic [15:0] ototal_q;
	logic olast_q;

	logic load;
	logic [7:0] cur_byte;
	logic [15:0] total_inc;
	logic byte_last;

	assign load = job_valid && (!out_valid_q || pop);

	always_comb begin
		case (k_q)
			2'd0: cur_byte = job.bits[23:16];
			2'd1: cur_byte = job.bits[15:8];
			default: cur_byte = job.bits[7:0];
		endcase
		total_inc = (total_q != TOTAL_MAX) ? total_q + 16'd1 : total_q;
		byte_last = (k_q == job.count - 2'd1);
		job_done = load && ((job.kind != JOB_BYTES) || byte_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			total_q <= '0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				if (job.kind == JOB_BYTES) begin
					crc_q <= crc_byte(crc_q, cur_byte);
					total_q <= total_inc;
					k_q <= byte_last ? 2'd0 : k_q + 2'd1;
				end else begin
					// status ends the message: back to the initial crc and count
					crc_q <= CRC_INIT;
					total_q <= '0;
					k_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			case (job.kind)
				JOB_BYTES: begin
					kind_q <= RK_DATA;
					byte_q <= cur_byte;
					ototal_q <= total_inc;
					olast_q <= byte_last;
				end
				JOB_CHECK: begin
					kind_q <= (job.bits == crc_q) ? RK_GOOD : RK_BAD;
					byte_q <= '0;
					ototal_q <= total_q;
					olast_q <= 1'b1;
				end
				default: begin
					kind_q <= RK_MALFORMED;
					byte_q <= '0;
					ototal_q <= total_q;
					olast_q <= 1'b1;
				end
			endcase
		end
	end

	assign empty = !out_valid_q;
	assign result_kind = kind_q;
	assign data_byte = byte_q;
	assign decoded_total = ototal_q;
	assign last_of_run = olast_q;

endmodule

// ===== src/armor_radix64_crc24_decoder.sv =====
// armor_radix64_crc24_decoder: top level of the radix-64 armor body decoder
// depends on armcrc_pkg, armcrc_front, armcrc_queue and armcrc_back
//
// input side is a queue: a character is taken on a clock edge with push high
// and full low. result side is a queue: while empty is low the oldest result
// is on result_kind, data_byte, decoded_total and last_of_run, and it leaves
// on an edge with pop high.
// the front takes one character per cycle while full is low, assembles four-symbol
// quanta and writes at most one job per character into a four-entry job queue. the
// back turns each job into results at one per cycle while results are popped: a full
// quantum gives up to three data bytes, each one run through crc-24.
// with the back idle, a character's job enters the job queue on the edge that takes
// it, and the back loads the first result from the queue head into its output
// register. sustained input rate is one character per cycle while quanta arrive
// no faster than the back drains them; a quantum of four symbols never gives more
// than three results, so plain body text streams without stalls on the input.
// when pop stays low the output register holds, the job queue fills and full
// rises; nothing is dropped. after reset the block is in body decoding with
// crc 0xb704ce and a zero byte count, and it returns there after every
// checksum or malformed status.
module armor_radix64_crc24_decoder (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] char_code,
	output logic empty,
	input logic pop,
	output logic [1:0] result_kind,
	output logic [7:0] data_byte,
	output logic [15:0] decoded_total,
	output logic last_of_run
);
	import armcrc_pkg::*;

	logic take;
	logic job_push;
	job_t job_in;
	logic job_valid;
	job_t job_head;
	logic job_done;

	assign take = push && !full;

	armcrc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.char_code(char_code),
		.job_push(job_push),
		.job(job_in)
	);

	armcrc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(job_push),
		.wr_job(job_in),
		.full(full),
		.rd_en(job_done),
		.rd_valid(job_valid),
		.rd_job(job_head)
	);

	armcrc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job(job_head),
		.job_done(job_done),
		.empty(empty),
		.pop(pop),
		.result_kind(result_kind),
		.data_byte(data_byte),
		.decoded_total(decoded_total),
		.last_of_run(last_of_run)
	);

endmodule

// ===== sim/armcrc_tb_pkg.sv =====
// armcrc_tb_pkg: radix-64 symbol lookup and crc-24 update shared by the testbench modules
// depends on armcrc_pkg for the crc constants and character codes
package armcrc_tb_pkg;
	import armcrc_pkg::*;

	// 0..63 for alphabet symbols, 64 for the pad, -1 for anything else
	function automatic int radix_value(input logic [7:0] c);
		if (c >= "A" && c <= "Z") begin
			return int'(c) - int'("A");
		end else if (c >= "a" && c <= "z") begin
			return int'(c) - int'("a") + 26;
		end else if (c >= "0" && c <= "9") begin
			return int'(c) - int'("0") + 52;
		end else if (c == CH_PLUS) begin
			return 62;
		end else if (c == CH_SLASH) begin
			return 63;
		end else if (c == CH_EQ) begin
			return 64;
		end
		return -1;
	endfunction

	function automatic logic [23:0] crc24_next(input logic [23:0] crc, input logic [7:0] b);
		logic [24:0] acc;
		acc = {1'b0, crc ^ {b, 16'h0000}};
		for (int i = 0; i < 8; i++) begin
			acc = acc << 1;
			if (acc[24]) begin
				acc = acc ^ CRC_POLY;
			end
		end
		return acc[23:0];
	endfunction

endpackage

// ===== sim/armor_decode_checker.sv =====
// armor_decode_checker: watches both queue sides of the armor decoder, decodes each
// accepted character itself and compares every popped result in order
// depends on armcrc_pkg and armcrc_tb_pkg
module armor_decode_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic [7:0] char_code,
	input logic empty,
	input logic pop,
	input logic [1:0] result_kind,
	input logic [7:0] data_byte,
	input logic [15:0] decoded_total,
	input logic last_of_run,
	output int fail_count,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import armcrc_pkg::*;
	import armcrc_tb_pkg::*;

	typedef struct packed {
		res_kind_t kind;
		logic [7:0] data;
		logic [15:0] total;
		logic last;
	} decoder_result_t;

	decoder_result_t results_due[$];

	phase_t phase;
	logic [23:0] quantum;
	logic [1:0] sym_idx;
	logic [1:0] pads;
	logic [23:0] crc;
	logic [15:0] byte_total;
	int fails;

	task automatic clear_state();
		phase = PH_BODY;
		quantum = '0;
		sym_idx = '0;
		pads = '0;
		crc = CRC_INIT;
		byte_total = '0;
	endtask

	task automatic post_status(input res_kind_t kind);
		results_due.push_back('{kind: kind, data: 8'h00, total: byte_total, last: 1'b1});
		clear_state();
	endtask

	task automatic decode_char(input logic [7:0] c);
		int v;
		int n;
		logic [7:0] b;
		if (c == CH_NUL) begin
			post_status(RK_MALFORMED);
			return;
		end
		if (phase == PH_WAIT) begin
			if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
				return;
			end
			if (c == CH_EQ) begin
				phase = PH_SUM;
				quantum = '0;
				sym_idx = '0;
				pads = '0;
				return;
			end
			post_status(RK_MALFORMED);
			return;
		end
		v = radix_value(c);
		if (v < 0) begin
			return;
		end
		if (v == 64) begin
			// pad at the start of a quantum: end of body, or pad-first checksum
			if (sym_idx == 0) begin
				if (phase == PH_SUM) begin
					post_status(crc == 24'd0 ? RK_GOOD : RK_BAD);
					return;
				end
				phase = PH_SUM;
				quantum = '0;
				pads = '0;
				return;
			end
			if (phase != PH_SUM && pads < 2'd3) begin
				pads = pads + 2'd1;
			end
			v = 0;
		end
		quantum = {quantum[17:0], 6'(v)};
		if (sym_idx < 2'd3) begin
			sym_idx = sym_idx + 2'd1;
			return;
		end
		sym_idx = '0;
		if (phase == PH_SUM) begin
			post_status(quantum == crc ? RK_GOOD : RK_BAD);
			return;
		end
		n = 3 - int'(pads);
		for (int k = 0; k < n; k++) begin
			b = quantum[23 - 8 * k -: 8];
			crc = crc24_next(crc, b);
			if (byte_total != TOTAL_MAX) begin
				byte_total = byte_total + 16'd1;
			end
			results_due.push_back('{kind: RK_DATA, data: b, total: byte_total,
				last: (k == n - 1)});
		end
		if (pads != 0) begin
			phase = PH_WAIT;
		end
		pads = '0;
		quantum = '0;
	endtask

	task automatic report(input string field, input int want, input int got);
		fails++;
		if (fails <= 60) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	task automatic check_result();
		decoder_result_t want;
		if (results_due.size() == 0) begin
			report("unexpected result, kind", -1, result_kind);
			return;
		end
		want = results_due.pop_front();
		if (result_kind !== want.kind) begin
			report("result_kind", want.kind, result_kind);
		end
		if (data_byte !== want.data) begin
			report("data_byte", want.data, data_byte);
		end
		if (decoded_total !== want.total) begin
			report("decoded_total", want.total, decoded_total);
		end
		if (last_of_run !== want.last) begin
			report("last_of_run", want.last, last_of_run);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			results_due.delete();
			fails = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (push && !full) begin
				decode_char(char_code);
			end
			if (pop && !empty) begin
				check_result();
			end
			fail_count <= fails;
			pending <= results_due.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// tb_top: drives armored text into armor_radix64_crc24_decoder and pops its results
// depends on armcrc_pkg, armcrc_tb_pkg, armor_decode_checker and the decoder rtl
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import armcrc_pkg::*;
	import armcrc_tb_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 270;

	typedef enum int {
		FL_NONE,
		FL_BADSUM,
		FL_PADFIRST,
		FL_LATEPAD,
		FL_NUL,
		FL_STRAY,
		FL_JUNK
	} flaw_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [7:0] char_code = 8'h00;
	logic pop = 1'b0;
	logic full;
	logic empty;
	logic [1:0] result_kind;
	logic [7:0] data_byte;
	logic [15:0] decoded_total;
	logic last_of_run;
	int fail_count;
	int pending;

	int cycles = 0;
	int burst_left = 0;
	int items = 0;
	int rx_mode = 0;
	int rx_left = 0;

	armor_radix64_crc24_decoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.char_code(char_code),
		.empty(empty),
		.pop(pop),
		.result_kind(result_kind),
		.data_byte(data_byte),
		.decoded_total(decoded_total),
		.last_of_run(last_of_run)
	);

	armor_decode_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.char_code(char_code),
		.empty(empty),
		.pop(pop),
		.result_kind(result_kind),
		.data_byte(data_byte),
		.decoded_total(decoded_total),
		.last_of_run(last_of_run),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** armor_radix64_crc24_decoder: FAILED **");
			$finish;
		end
	end

	// receiver: switches between free running, coin-flip, periodic and light stalls
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(8, 80);
		end
		rx_left--;
		case (rx_mode)
			0: pop <= 1'b1;
			1: pop <= 1'($urandom_range(0, 1));
			2: pop <= (rx_left % 5) != 0;
			default: pop <= ($urandom_range(0, 3) != 0);
		endcase
	end

	function automatic logic [7:0] radix_char(input logic [5:0] v);
		if (v < 26) begin
			return 8'("A" + v);
		end else if (v < 52) begin
			return 8'("a" + v - 26);
		end else if (v < 62) begin
			return 8'("0" + v - 52);
		end else if (v == 62) begin
			return CH_PLUS;
		end
		return CH_SLASH;
	endfunction

	// one transfer; the sender runs in bursts with random gaps in between
	task automatic send_char(input logic [7:0] c);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		push <= 1'b1;
		char_code <= c;
		@(posedge clk);
		while (full) @(posedge clk);
		burst_left--;
		items++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i]);
		end
	endtask

	// occasional whitespace, and with allow_noise a character outside the alphabet
	task automatic send_filler(input bit allow_noise);
		logic [7:0] c;
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) begin
			send_char(CH_SPACE);
		end else if (r < 8) begin
			send_char(CH_LF);
		end else if (r < 10) begin
			send_char(CH_CR);
		end else if (r < 12) begin
			send_char(CH_TAB);
		end else if (allow_noise && r < 16) begin
			do begin
				c = 8'($urandom_range(1, 255));
			end while (radix_value(c) >= 0);
			send_char(c);
		end
	endtask

	task automatic send_message(input int nbytes, input flaw_t flaw);
		logic [7:0] body[$];
		logic [7:0] b;
		logic [23:0] crc;
		logic [23:0] grp;
		logic [23:0] sum;
		logic [7:0] c;
		int g;
		int nul_at;
		crc = CRC_INIT;
		for (int i = 0; i < nbytes; i++) begin
			b = 8'($urandom);
			crc = crc24_next(crc, b);
			body.push_back(b);
		end
		for (int i = 0; i < nbytes; i += 3) begin
			g = (nbytes - i < 3) ? nbytes - i : 3;
			grp = {body[i], (g > 1) ? body[i + 1] : 8'h00, (g > 2) ? body[i + 2] : 8'h00};
			for (int k = 0; k < 4; k++) begin
				send_filler(1'b1);
				send_char(k > g ? CH_EQ : radix_char(grp[23 - 6 * k -: 6]));
			end
		end
		if (flaw == FL_JUNK) begin
			repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
		end
		repeat ($urandom_range(0, 2)) send_filler(1'b0);
		if (flaw == FL_STRAY) begin
			do begin
				c = 8'($urandom_range(1, 255));
			end while (c == CH_EQ || c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR);
			send_char(c);
		end
		send_char(CH_EQ);
		if (flaw == FL_PADFIRST) begin
			send_char(CH_EQ);
			return;
		end
		sum = crc;
		if (flaw == FL_BADSUM) begin
			sum[$urandom_range(0, 23)] ^= 1'b1;
		end
		nul_at = (flaw == FL_NUL) ? $urandom_range(0, 3) : 4;
		for (int k = 0; k < 4; k++) begin
			send_filler(1'b1);
			if (k == nul_at) begin
				send_char(CH_NUL);
				return;
			end
			send_char((flaw == FL_LATEPAD && k >= 2) ? CH_EQ : radix_char(sum[23 - 6 * k -: 6]));
		end
	endtask

	initial begin
		int r;
		flaw_t flaw;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte body, whitespace while waiting, then a pad-first checksum
		send_text("AA==\n==");
		// two-byte body, then a stray character while waiting
		send_text("//8=x");
		// ordinary symbols after a pad, then end of text
		send_text("A=B+");
		send_char(CH_NUL);
		// three pads drop every byte; checksum with later pads
		send_text("A====A===");
		// empty body with the initial crc as checksum
		send_text("=twTO");

		items = 0;
		while (items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 60) flaw = FL_NONE;
			else if (r < 70) flaw = FL_BADSUM;
			else if (r < 75) flaw = FL_PADFIRST;
			else if (r < 80) flaw = FL_LATEPAD;
			else if (r < 86) flaw = FL_NUL;
			else if (r < 92) flaw = FL_STRAY;
			else flaw = FL_JUNK;
			send_message(($urandom_range(0, 9) == 0) ? $urandom_range(20, 45)
				: $urandom_range(0, 10), flaw);
		end

		push <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("** armor_radix64_crc24_decoder: PASSED **");
		end else begin
			$display("** armor_radix64_crc24_decoder: FAILED **");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/armcrc_pkg.sv
src/armcrc_front.sv
src/armcrc_queue.sv
src/armcrc_back.sv
src/armor_radix64_crc24_decoder.sv
sim/armcrc_tb_pkg.sv
sim/armor_decode_checker.sv
sim/tb_top.sv
